/* src/mmpn_pkg.sv */
// Package for the min/max preview normalizer.
// Holds widths, beat payload types and the queue entry type; no dependencies.
`timescale 1ns / 1ps

package mmpn_pkg;

    // Pixel word width (signed fixed point, fraction bits do not affect the ratio)
    localparam int PIXEL_BITS  = 32;
    // Preview byte width and full-scale value
    localparam int PREVIEW_BITS = 8;
    localparam logic [PREVIEW_BITS-1:0] PREVIEW_MAX = '1;
    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                         mode;
        logic signed [PIXEL_BITS-1:0] pixel_value;
        logic                         frame_start;
        logic                         frame_end;
    } mmpn_in_t;

    typedef struct packed {
        logic [PREVIEW_BITS-1:0] preview_byte;
        logic                    last_pixel;
    } mmpn_out_t;

    // Decoded operation carried through the queue
    typedef enum logic {
        OP_MEASURE,
        OP_MAP
    } mmpn_op_t;

    typedef struct packed {
        mmpn_op_t                     op;
        logic signed [PIXEL_BITS-1:0] pixel;
        logic                         restart;
        logic                         last;
    } mmpn_entry_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
    } mmpn_qstat_t;

endpackage

/* src/mmpn_front.sv */
// Front end of the min/max preview normalizer: accepts pixel beats,
// decodes them and holds them in a short queue. Depends on mmpn_pkg.
`timescale 1ns / 1ps

module mmpn_front #(
    parameter int QUEUE_DEPTH = mmpn_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  mmpn_pkg::mmpn_in_t    pixel,
    output mmpn_pkg::mmpn_entry_t q_entry,
    output mmpn_pkg::mmpn_qstat_t q_stat,
    input  logic                  q_pop
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    mmpn_pkg::mmpn_entry_t queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    mmpn_pkg::mmpn_entry_t push_entry;
    logic push;
    logic pop;

    // Decode the beat into a queue entry
    always_comb
    begin
        push_entry.op      = pixel.mode ? mmpn_pkg::OP_MAP : mmpn_pkg::OP_MEASURE;
        push_entry.pixel   = pixel.pixel_value;
        push_entry.restart = pixel.frame_start & ~pixel.mode;
        push_entry.last    = pixel.frame_end;
    end

    assign pixel_stall  = (count_reg == CNT_FULL);
    assign push         = pixel_valid & ~pixel_stall;
    assign pop          = q_pop & (count_reg != '0);
    assign q_entry      = queue_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = pixel_stall;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the accepted beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/mmpn_back.sv */
// Back end of the min/max preview normalizer: tracks frame min/max and maps
// pixels with an 8-step restoring divider. Depends on mmpn_pkg.
`timescale 1ns / 1ps

module mmpn_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmpn_pkg::mmpn_entry_t q_entry,
    input  mmpn_pkg::mmpn_qstat_t q_stat,
    output logic                  q_pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mmpn_pkg::mmpn_out_t   result
);

    localparam int PB       = mmpn_pkg::PIXEL_BITS;
    localparam int QB       = mmpn_pkg::PREVIEW_BITS;
    localparam int REM_BITS = PB + QB;
    localparam int STEP_BITS = $clog2(QB);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic signed [PB-1:0] MIN_RESET = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] MAX_RESET = {1'b1, {(PB-1){1'b0}}};
    localparam logic [STEP_BITS-1:0] STEP_FIRST = STEP_BITS'(QB - 1);

    logic [1:0] state_reg, state_next;
    logic signed [PB-1:0] min_reg, min_next;
    logic signed [PB-1:0] max_reg, max_next;
    logic signed [PB:0]   diff_reg, diff_next;
    logic [PB-1:0]        range_reg, range_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [REM_BITS-1:0]  dvs_reg, dvs_next;
    logic [QB-1:0]        quot_reg, quot_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    mmpn_pkg::mmpn_out_t  out_reg, out_next;

    logic signed [PB:0]  diff_full;
    logic signed [PB:0]  range_full;
    logic [PB-1:0]       diff_mag;
    logic                out_free;
    logic                rem_ge;

    assign out_free     = ~out_valid_reg | ~result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Offset from minimum and span of the current frame
    assign diff_full  = $signed({q_entry.pixel[PB-1], q_entry.pixel})
                      - $signed({min_reg[PB-1], min_reg});
    assign range_full = $signed({max_reg[PB-1], max_reg})
                      - $signed({min_reg[PB-1], min_reg});
    assign diff_mag   = diff_reg[PB-1:0];
    assign rem_ge     = (rem_reg >= dvs_reg);

    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        diff_next      = diff_reg;
        range_next     = range_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg & result_stall;
        out_next       = out_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.op == mmpn_pkg::OP_MEASURE)
                    begin
                        // Reload or widen the running bounds
                        if (q_entry.restart)
                        begin
                            min_next = q_entry.pixel;
                            max_next = q_entry.pixel;
                        end
                        else
                        begin
                            if (q_entry.pixel < min_reg)
                            begin
                                min_next = q_entry.pixel;
                            end
                            if (q_entry.pixel > max_reg)
                            begin
                                max_next = q_entry.pixel;
                            end
                        end
                    end
                    else
                    begin
                        // Capture offset and span, floor span at one LSB
                        diff_next  = diff_full;
                        last_next  = q_entry.last;
                        if (range_full[PB] || range_full == '0)
                        begin
                            range_next = PB'(1);
                        end
                        else
                        begin
                            range_next = range_full[PB-1:0];
                        end
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                // Clamp outside the span, otherwise start the divider
                if (diff_reg[PB] || diff_reg == '0)
                begin
                    quot_next  = '0;
                    state_next = ST_EMIT;
                end
                else if (diff_mag >= range_reg)
                begin
                    quot_next  = mmpn_pkg::PREVIEW_MAX;
                    state_next = ST_EMIT;
                end
                else
                begin
                    rem_next   = {diff_mag, QB'(0)} - {QB'(0), diff_mag};
                    dvs_next   = {1'b0, range_reg, (QB-1)'(0)};
                    quot_next  = '0;
                    step_next  = STEP_FIRST;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // One quotient bit per cycle
                if (rem_ge)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                quot_next = {quot_reg[QB-2:0], rem_ge};
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // Hand the byte to the output register once it is free
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.preview_byte = quot_reg;
                    out_next.last_pixel   = last_reg;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        range_reg <= range_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        last_reg  <= last_next;
        out_reg   <= out_next;
    end

endmodule

/* src/min_max_preview_normalizer.sv */
// Min/max contrast stretch of a signed fixed-point pixel stream to 8 bits.
// Frame is streamed twice: measure beats (mode 0) track min and max, map
// beats (mode 1) return floor((pixel - min) * 255 / range), range >= 1 LSB.
// Channels: pixel (pixel_valid / pixel_stall) in, result (result_valid /
// result_stall) out; a beat moves when valid is high and stall is low.
// Only map beats produce a result beat, in the order they were accepted.
// A map result passes from the queue through the check and emit states
// when the pixel lies outside the measured span, and also through the
// states of the 8-step restoring divider when it needs the divider. Measure
// beats retire one per cycle while no map beat holds the back end.
// A queue of QUEUE_DEPTH beats keeps the input open while the back end
// works; pixel_stall rises only when that queue is full.
// Reset clears the queue and output register and sets min to the largest
// and max to the most negative value, so early maps see a one-LSB range.
// When result_stall is high the result beat holds; the back end finishes
// the next beat and waits, and the queue then fills and stalls the input.
// Depends on mmpn_pkg, mmpn_front and mmpn_back.
`timescale 1ns / 1ps

module min_max_preview_normalizer #(
    parameter int QUEUE_DEPTH = mmpn_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  mmpn_pkg::mmpn_in_t  pixel,
    output logic                result_valid,
    input  logic                result_stall,
    output mmpn_pkg::mmpn_out_t result
);

    mmpn_pkg::mmpn_entry_t q_entry;
    mmpn_pkg::mmpn_qstat_t q_stat;
    logic                  q_pop;

    // Accept and decode beats into the queue
    mmpn_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .q_entry     (q_entry),
        .q_stat      (q_stat),
        .q_pop       (q_pop)
    );

    // Update bounds and map pixels
    mmpn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (q_entry),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("queue popped while empty");

    // A full queue is never reported empty
    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> q_stat.valid)
        else $error("queue full but not valid");

    // Retiring a measure beat cannot start a result beat next cycle
    a_measure_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.op == mmpn_pkg::OP_MEASURE) |=> !$rose(result_valid))
        else $error("result produced by a measure beat");
`endif

endmodule

/* sim/mmpn_stretch_monitor.sv */
// Monitor for the min/max preview normalizer: predicts each preview byte and
// checks the result channel against it. Depends on mmpn_pkg.
`timescale 1ns / 1ps

module mmpn_stretch_monitor
    import mmpn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pixel_valid,
    input  logic      pixel_stall,
    input  mmpn_in_t  pixel,
    input  logic      result_valid,
    input  logic      result_stall,
    input  mmpn_out_t result,
    output int        fail_count,
    output int        pending
);

    // Running span of the measure pass
    logic signed [PIXEL_BITS-1:0] span_lo;
    logic signed [PIXEL_BITS-1:0] span_hi;
    // Preview beats predicted but not yet seen on the result channel
    mmpn_out_t                    preview_due[$];

    // Stretch one pixel against the current span; the span never drops below one LSB
    function automatic logic [PREVIEW_BITS-1:0] stretch_byte(
        input logic signed [PIXEL_BITS-1:0] px,
        input logic signed [PIXEL_BITS-1:0] lo,
        input logic signed [PIXEL_BITS-1:0] hi
    );
        longint offset;
        longint span;
        offset = longint'(px) - longint'(lo);
        span   = longint'(hi) - longint'(lo);
        if (span < 1)
            span = 1;
        if (offset <= 0)
            return '0;
        if (offset >= span)
            return PREVIEW_MAX;
        return PREVIEW_BITS'((offset * longint'(PREVIEW_MAX)) / span);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mmpn_out_t want;
        mmpn_out_t due;
        if (!rst_n)
        begin
            span_lo = {1'b0, {(PIXEL_BITS-1){1'b1}}};
            span_hi = {1'b1, {(PIXEL_BITS-1){1'b0}}};
            preview_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Check the result beat against the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (preview_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat: got byte %0d last %0b",
                             $time, result.preview_byte, result.last_pixel);
                    fail_count++;
                end
                else
                begin
                    due = preview_due.pop_front();
                    if (result.preview_byte !== due.preview_byte)
                    begin
                        $display("%0t: preview_byte mismatch: expected %0d, got %0d",
                                 $time, due.preview_byte, result.preview_byte);
                        fail_count++;
                    end
                    if (result.last_pixel !== due.last_pixel)
                    begin
                        $display("%0t: last_pixel mismatch: expected %0b, got %0b",
                                 $time, due.last_pixel, result.last_pixel);
                        fail_count++;
                    end
                end
            end

            // Advance the span on measure beats, predict a byte on map beats
            if (pixel_valid && !pixel_stall)
            begin
                if (pixel.mode == OP_MAP)
                begin
                    want.preview_byte = stretch_byte(pixel.pixel_value, span_lo, span_hi);
                    want.last_pixel   = pixel.frame_end;
                    preview_due.push_back(want);
                end
                else if (pixel.frame_start)
                begin
                    span_lo = pixel.pixel_value;
                    span_hi = pixel.pixel_value;
                end
                else
                begin
                    if (pixel.pixel_value < span_lo)
                        span_lo = pixel.pixel_value;
                    if (pixel.pixel_value > span_hi)
                        span_hi = pixel.pixel_value;
                end
            end
            pending = preview_due.size();
        end
    end

endmodule

/* sim/min_max_preview_normalizer_tb.sv */
// Top of the min/max preview normalizer bench: clock, reset, pixel stimulus,
// result back-pressure and verdict. Depends on mmpn_pkg, mmpn_stretch_monitor and the block.
`timescale 1ns / 1ps

module min_max_preview_normalizer_tb;
    import mmpn_pkg::*;

    localparam int PIXEL_TARGET = 650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int FRAME_MAX    = 16;

    logic      clk;
    logic      rst_n;
    logic      pixel_valid;
    logic      pixel_stall;
    mmpn_in_t  pixel;
    logic      result_valid;
    logic      result_stall;
    mmpn_out_t result;

    int fail_count;
    int pending;
    int pixels_sent;
    int burst_left;
    int idle_cycles;

    logic signed [PIXEL_BITS-1:0] frame_px[FRAME_MAX];
    int                           frame_len;
    int                           spread_kind;
    logic signed [PIXEL_BITS-1:0] frame_base;

    min_max_preview_normalizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    mmpn_stretch_monitor monitor_u (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Stall the result channel in stretches: open, light random, heavy random
    initial
    begin
        int style;
        int stretch;
        result_stall = 1'b0;
        forever
        begin
            style   = $urandom_range(0, 2);
            stretch = $urandom_range(5, 60);
            repeat (stretch)
            begin
                @(negedge clk);
                case (style)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 2) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("min_max_preview_normalizer regression: fail");
                $finish;
            end
        end
    end

    // Drive one pixel beat at the falling edge and hold it until accepted
    task automatic send_pixel(input mmpn_op_t op, input logic signed [PIXEL_BITS-1:0] px,
                              input logic start, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        pixel.mode        <= op;
        pixel.pixel_value <= px;
        pixel.frame_start <= start;
        pixel.frame_end   <= last;
        pixel_valid       <= 1'b1;
        do
            @(posedge clk);
        while (pixel_stall);
        @(negedge clk);
        burst_left--;
        pixels_sent++;
    endtask

    // Pixel near the frame base, spread set by the frame's kind (kind 0: any value)
    function automatic logic signed [PIXEL_BITS-1:0] frame_pixel(
        input logic signed [PIXEL_BITS-1:0] base, input int kind
    );
        case (kind)
            0:       return $urandom;
            1:       return base + $urandom_range(0, 3);
            2:       return base + $urandom_range(0, 255);
            3:       return base + $urandom_range(0, 65535);
            default: return base;
        endcase
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        pixels_sent = 0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Map before any measure: span is one LSB against the reset bounds
        send_pixel(OP_MAP, 32'sh0000_0000, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sh7fff_ffff, 1'b1, 1'b1);
        send_pixel(OP_MAP, 32'sh8000_0000, 1'b0, 1'b0);
        // Full-scale span; frame_end on a measure beat does nothing
        send_pixel(OP_MEASURE, 32'sh8000_0000, 1'b1, 1'b1);
        send_pixel(OP_MEASURE, 32'sh7fff_ffff, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sh8000_0000, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sh7fff_ffff, 1'b0, 1'b1);
        send_pixel(OP_MAP, 32'sh0000_0000, 1'b1, 1'b0);
        send_pixel(OP_MAP, 32'sh8000_0001, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'shffff_ffff, 1'b0, 1'b0);
        // Flat frame, then widen it without a restart
        send_pixel(OP_MEASURE, 32'sd100, 1'b1, 1'b0);
        send_pixel(OP_MAP, 32'sd100, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sd101, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sd99, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sh8000_0000, 1'b0, 1'b1);
        send_pixel(OP_MEASURE, 32'sd110, 1'b0, 1'b0);
        send_pixel(OP_MEASURE, 32'sd95, 1'b0, 1'b1);
        send_pixel(OP_MAP, 32'sd95, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sd110, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sd105, 1'b1, 1'b0);
        send_pixel(OP_MAP, 32'sd200, 1'b0, 1'b0);
        send_pixel(OP_MAP, 32'sd94, 1'b0, 1'b1);

        // Random frames: measure pass then map pass, with some noise and broken frames
        while (pixels_sent < PIXEL_TARGET)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 5))
                    send_pixel(mmpn_op_t'($urandom_range(0, 1)), $urandom,
                               1'($urandom), 1'($urandom));
            end
            else
            begin
                frame_len   = $urandom_range(1, FRAME_MAX);
                spread_kind = $urandom_range(0, 4);
                frame_base  = $urandom;
                for (int i = 0; i < frame_len; i++)
                    frame_px[i] = frame_pixel(frame_base, spread_kind);
                // Measure pass; now and then the restart is left out
                for (int i = 0; i < frame_len; i++)
                    send_pixel(OP_MEASURE, frame_px[i],
                               (i == 0) && ($urandom_range(0, 9) != 0),
                               (i == frame_len - 1) || ($urandom_range(0, 15) == 0));
                // Map pass; some pixels fall outside the measured span
                for (int i = 0; i < frame_len; i++)
                    send_pixel(OP_MAP,
                               ($urandom_range(0, 4) == 0) ? frame_pixel(frame_base, 0)
                                                           : frame_px[i],
                               1'($urandom_range(0, 7) == 0),
                               i == frame_len - 1);
            end
        end
        pixel_valid <= 1'b0;

        // Drain, then let any stray beat show up
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("min_max_preview_normalizer regression: pass");
        else
            $display("min_max_preview_normalizer regression: fail");
        $finish;
    end

endmodule

/* files.f */
src/mmpn_pkg.sv
src/mmpn_front.sv
src/mmpn_back.sv
src/min_max_preview_normalizer.sv
sim/mmpn_stretch_monitor.sv
sim/min_max_preview_normalizer_tb.sv
